[rtl/pdo_pkg.sv]
// Shared types and constants of the PPS-disciplined oscillator controller.
package pdo_pkg;

    localparam int TS_W    = 32;
    localparam int FREQ_W  = 56;
    localparam int WORD_W  = 12;
    localparam int DIVD_W  = 81;
    localparam int DIVS_W  = 32;
    localparam int QUO_W   = 64;
    localparam int MULA_W  = 33;
    localparam int MULB_W  = 32;
    localparam int PROD_W  = MULA_W + MULB_W;
    localparam int OUT_W   = FREQ_W + 2 * WORD_W;

    typedef logic [1:0] req_t;
    localparam req_t REQ_REF  = 2'd0;
    localparam req_t REQ_OSC  = 2'd1;
    localparam req_t REQ_TICK = 2'd2;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NOPAIR = 2'd0;
    localparam kind_t KIND_PAIR   = 2'd1;
    localparam kind_t KIND_DAC    = 2'd2;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_GAIN_P  = 3'd0;
    localparam cfg_idx_t CFG_GAIN_I  = 3'd1;
    localparam cfg_idx_t CFG_GAIN_D  = 3'd2;
    localparam cfg_idx_t CFG_SMOOTH  = 3'd3;
    localparam cfg_idx_t CFG_OFFSET  = 3'd4;
    localparam cfg_idx_t CFG_PERIOD  = 3'd5;
    localparam cfg_idx_t CFG_RATE    = 3'd6;
    localparam cfg_idx_t CFG_RANGE   = 3'd7;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic [MULA_W-1:0] a;
        logic [MULB_W-1:0] b;
    } mul_req_t;

endpackage

[rtl/pps_disciplined_oscillator_pid.sv]
// Top level: PPS capture pairing, frequency history and PID to DAC word.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  tdata: timestamp; tuser: req_type
//  m_       out        m_tvalid / m_tready  tdata: freq, vco_target, dac; tuser: kind
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time; s_tready is high only when the sequencer is idle.
// Capture: push, then pair search over the stored stamps, then the multiply
// and the 81-bit serial division on a match.
// Tick with a new measurement: a pass over the frequency history, up to two
// divisions and the multiply steps; a plain tick runs only the filter steps.
// Synchronous active-low reset; no clearing pass. A result may wait in the
// output register while the next transaction is accepted.
module pps_disciplined_oscillator_pid #(
    parameter int HISTORY_DEPTH = 16,
    parameter int INITIAL_WORD  = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] timestamp
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [55:0] measured_freq, [67:56] vco_target, [79:68] dac_value
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pdo_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_FMUL, ST_FSTART, ST_FDIV,
        ST_SUM_RD, ST_SUM_ACC, ST_INT_PREP, ST_IDIV, ST_DER_LO, ST_DER_HI,
        ST_DER_ACC, ST_MG_LO, ST_MG_HI, ST_MG_ACC, ST_XMUL, ST_XCALC, ST_WDIV,
        ST_FLT1, ST_FLT2, ST_FLT3, ST_DONE
    } state_t;

    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] idx);
        logic [AW:0] diff;
        logic [AW:0] wrapped;
        diff    = {1'b0, head} - {1'b0, idx};
        wrapped = diff + (AW+1)'(HISTORY_DEPTH);
        ring_addr = diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] head);
        ring_inc = (head == AW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
    endfunction

    function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] cnt);
        cnt_inc = (cnt == CW'(HISTORY_DEPTH)) ? cnt : cnt + 1'b1;
    endfunction

    state_t state_reg;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, offset_reg;
    logic [16:0]        smooth_reg;
    logic [30:0]        period_reg, range_reg;
    logic [9:0]         rate_reg;

    logic [AW-1:0]      rhead_reg, ohead_reg, fhead_reg;
    logic [CW-1:0]      rcnt_reg, ocnt_reg, fcnt_reg;
    logic               new_flag_reg;
    logic [WORD_W-1:0]  target_reg, filt_reg;
    logic [FREQ_W-1:0]  newest_reg;

    logic [AW-1:0]      i_reg, j_reg, k_reg;
    logic [31:0]        den_reg;
    logic signed [63:0] sum_reg, e_reg, integ_reg, der_reg;
    logic [FREQ_W-1:0]  prev_reg, f1_reg;
    logic signed [FREQ_W:0] diff_reg;
    logic [63:0]        plo_reg;
    logic [1:0]         term_reg;
    logic signed [43:0] asum_reg;

    logic               div_start_reg;
    logic [DIVD_W-1:0]  div_dvd_reg;
    logic [DIVS_W-1:0]  div_dvs_reg;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;
    div_req_t           div_req;
    mul_req_t           mul_req;
    logic [PROD_W-1:0]  product;

    logic               m_tvalid_reg;
    kind_t              kind_reg, m_kind_reg;
    logic [OUT_W-1:0]   m_data_reg;

    // effective configuration
    logic [30:0]        p_eff, range_eff;
    logic [9:0]         fr_eff;
    logic [16:0]        nf;
    logic [49:0]        r_q40;

    assign p_eff     = (period_reg < 31'd2) ? 31'd2 : period_reg;
    assign range_eff = (range_reg == '0) ? 31'd1 : range_reg;
    assign fr_eff    = (rate_reg == '0) ? 10'd1 : rate_reg;
    assign nf        = (smooth_reg > 17'h10000) ? 17'h10000 : smooth_reg;
    assign r_q40     = {fr_eff, 40'b0};

    // input side
    logic s_accept, ref_push, osc_push;
    logic [CW-1:0] rcnt_new, ocnt_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign ref_push = s_accept && (s_tuser == REQ_REF);
    assign osc_push = s_accept && (s_tuser == REQ_OSC);
    assign rcnt_new = ref_push ? cnt_inc(rcnt_reg) : rcnt_reg;
    assign ocnt_new = osc_push ? cnt_inc(ocnt_reg) : ocnt_reg;

    // stores
    logic [TS_W-1:0]   ref_rd, osc_rd;
    logic [FREQ_W-1:0] freq_rd;
    logic              freq_wr;

    assign freq_wr = (state_reg == ST_FDIV) && div_done;

    pdo_ram #(.WIDTH(TS_W), .DEPTH(HISTORY_DEPTH)) u_ref_ram (
        .aclk, .wr_en(ref_push), .wr_addr(ring_inc(rhead_reg)), .wr_data(s_tdata),
        .rd_addr(ring_addr(rhead_reg, j_reg)), .rd_data(ref_rd)
    );

    pdo_ram #(.WIDTH(TS_W), .DEPTH(HISTORY_DEPTH)) u_osc_ram (
        .aclk, .wr_en(osc_push), .wr_addr(ring_inc(ohead_reg)), .wr_data(s_tdata),
        .rd_addr(ring_addr(ohead_reg, i_reg)), .rd_data(osc_rd)
    );

    pdo_ram #(.WIDTH(FREQ_W), .DEPTH(HISTORY_DEPTH)) u_freq_ram (
        .aclk, .wr_en(freq_wr), .wr_addr(ring_inc(fhead_reg)),
        .wr_data(div_quo[FREQ_W-1:0]),
        .rd_addr(ring_addr(fhead_reg, k_reg)), .rd_data(freq_rd)
    );

    // arithmetic units
    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_dvd_reg;
    assign div_req.divisor  = div_dvs_reg;

    pdo_div u_div (.aclk, .aresetn, .req(div_req), .done(div_done), .quotient(div_quo));
    pdo_mul u_mul (.aclk, .req(mul_req), .product(product));

    // pair compare
    logic signed [32:0] den33;
    logic [32:0]        dmag;
    logic               pair_hit;
    logic [31:0]        udiff;

    assign udiff    = osc_rd - ref_rd;
    assign dmag     = udiff[31] ? (33'd0 - {1'b1, udiff}) : {1'b0, udiff};
    assign pair_hit = {dmag, 1'b0} <= {3'b0, p_eff};
    assign den33    = $signed({udiff[31], udiff}) + $signed({2'b0, p_eff});

    // gain term operands
    logic signed [63:0] ga;
    logic signed [31:0] gg;
    logic [63:0]        ua;
    logic [31:0]        ug;
    logic               tneg;
    logic [56:0]        dfmag;

    always_comb begin
        unique case (term_reg)
            2'd0:    begin ga = e_reg;     gg = gain_p_reg; end
            2'd1:    begin ga = integ_reg; gg = gain_i_reg; end
            default: begin ga = der_reg;   gg = gain_d_reg; end
        endcase
    end

    assign ua    = ga[63] ? 64'(-ga) : 64'(ga);
    assign ug    = gg[31] ? 32'(-gg) : 32'(gg);
    assign tneg  = ga[63] ^ gg[31];
    assign dfmag = diff_reg[FREQ_W] ? 57'(-diff_reg) : 57'(diff_reg);

    logic [64:0]        acc2;
    logic [56:0]        mraw;
    logic [40:0]        msat;
    assign acc2 = 65'(product[63:0]) + 65'(plo_reg[63:32]);
    assign mraw = acc2[64:8];
    assign msat = (mraw > 57'h100_0000_0000) ? 41'h100_0000_0000 : mraw[40:0];

    // sum saturation and mapping
    logic signed [43:0] asat;
    logic [32:0]        amag;
    logic signed [66:0] xv, sv;
    logic [63:0]        dmag64;

    assign asat = (asum_reg > 44'sh1_0000_0000) ? 44'sh1_0000_0000 :
                  (asum_reg < -44'sh1_0000_0000) ? -44'sh1_0000_0000 : asum_reg;
    assign amag = asat[43] ? 33'(-asat) : 33'(asat);
    assign xv   = asum_reg[43] ? -$signed({2'b0, product}) : $signed({2'b0, product});
    assign sv   = xv + 67'(offset_reg) + $signed({36'b0, range_eff});
    assign dmag64 = {product[31:0], 32'b0} + plo_reg;

    logic signed [63:0] sum_term;
    assign sum_term = $signed({13'b0, r_q40, 1'b0}) - $signed({8'b0, prev_reg})
                    - $signed({8'b0, freq_rd});

    // divider launch and output load
    logic div_go, out_load;
    assign div_go   = (state_reg == ST_FSTART) || (state_reg == ST_INT_PREP) ||
                      ((state_reg == ST_XCALC) && !sv[66] &&
                       !(sv >= $signed({35'b0, range_eff, 1'b0})));
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            ST_FMUL:   begin mul_req.a = 33'(fr_eff);        mul_req.b = 32'(p_eff); end
            ST_DER_LO: begin mul_req.a = 33'(dfmag[31:0]);   mul_req.b = 32'(fr_eff); end
            ST_DER_HI: begin mul_req.a = 33'(dfmag[56:32]);  mul_req.b = 32'(fr_eff); end
            ST_MG_LO:  begin mul_req.a = 33'(ua[31:0]);      mul_req.b = ug; end
            ST_MG_HI:  begin mul_req.a = 33'(ua[63:32]);     mul_req.b = ug; end
            ST_XMUL:   begin mul_req.a = amag;               mul_req.b = 32'(p_eff); end
            ST_FLT1:   begin mul_req.a = 33'(filt_reg);      mul_req.b = 32'(nf); end
            ST_FLT2:   begin mul_req.a = 33'(target_reg);
                             mul_req.b = 32'(17'h10000 - nf); end
            default:   mul_req = '0;
        endcase
    end

    logic [30:0] fsum;
    assign fsum = 31'(plo_reg[29:0]) + 31'(product[29:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gain_p_reg    <= 32'sd167772;
            gain_i_reg    <= 32'sd100663;
            gain_d_reg    <= 32'sd167772;
            smooth_reg    <= 17'd3277;
            offset_reg    <= 32'sd21810381;
            period_reg    <= 31'd10000000;
            rate_reg      <= 10'd1;
            range_reg     <= 31'd117440512;
            rhead_reg     <= '0;
            ohead_reg     <= '0;
            fhead_reg     <= '0;
            rcnt_reg      <= '0;
            ocnt_reg      <= '0;
            fcnt_reg      <= '0;
            new_flag_reg  <= 1'b0;
            target_reg    <= WORD_W'(INITIAL_WORD);
            filt_reg      <= WORD_W'(INITIAL_WORD);
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            div_start_reg <= div_go;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_GAIN_P: gain_p_reg <= cfg_data;
                    CFG_GAIN_I: gain_i_reg <= cfg_data;
                    CFG_GAIN_D: gain_d_reg <= cfg_data;
                    CFG_SMOOTH: smooth_reg <= cfg_data[16:0];
                    CFG_OFFSET: offset_reg <= cfg_data;
                    CFG_PERIOD: period_reg <= cfg_data[30:0];
                    CFG_RATE:   rate_reg   <= cfg_data[9:0];
                    CFG_RANGE:  range_reg  <= cfg_data[30:0];
                    default:    ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (ref_push) rhead_reg <= ring_inc(rhead_reg);
                    if (osc_push) ohead_reg <= ring_inc(ohead_reg);
                    rcnt_reg <= rcnt_new;
                    ocnt_reg <= ocnt_new;
                    i_reg    <= '0;
                    j_reg    <= '0;
                    k_reg    <= '0;
                    sum_reg  <= '0;
                    if (ref_push || osc_push) begin
                        kind_reg  <= KIND_NOPAIR;
                        state_reg <= (rcnt_new != '0 && ocnt_new != '0) ? ST_SRCH_RD
                                                                        : ST_DONE;
                    end else if (s_accept && s_tuser == REQ_TICK) begin
                        kind_reg     <= KIND_DAC;
                        new_flag_reg <= 1'b0;
                        state_reg    <= (new_flag_reg && fcnt_reg != '0) ? ST_SUM_RD
                                                                         : ST_FLT1;
                    end
                end
                ST_SRCH_RD: state_reg <= ST_SRCH_CMP;
                ST_SRCH_CMP: begin
                    if (pair_hit) begin
                        den_reg   <= den33[31:0];
                        rcnt_reg  <= CW'(j_reg);
                        ocnt_reg  <= CW'(i_reg);
                        state_reg <= ST_FMUL;
                    end else if (CW'(j_reg) + 1'b1 == rcnt_reg) begin
                        j_reg <= '0;
                        if (CW'(i_reg) + 1'b1 == ocnt_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_SRCH_RD;
                        end
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_SRCH_RD;
                    end
                end
                ST_FMUL: state_reg <= ST_FSTART;
                ST_FSTART: begin
                    div_dvd_reg   <= {product[40:0], 40'b0};
                    div_dvs_reg   <= den_reg;
                    state_reg     <= ST_FDIV;
                end
                ST_FDIV: begin
                    if (div_done) begin
                        fhead_reg    <= ring_inc(fhead_reg);
                        fcnt_reg     <= cnt_inc(fcnt_reg);
                        newest_reg   <= div_quo[FREQ_W-1:0];
                        new_flag_reg <= 1'b1;
                        kind_reg     <= KIND_PAIR;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_SUM_RD: state_reg <= ST_SUM_ACC;
                ST_SUM_ACC: begin
                    if (k_reg != '0) sum_reg <= sum_reg + sum_term;
                    if (k_reg == AW'(1)) f1_reg <= freq_rd;
                    prev_reg <= freq_rd;
                    if (CW'(k_reg) + 1'b1 == fcnt_reg) begin
                        state_reg <= ST_INT_PREP;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_INT_PREP: begin
                    e_reg    <= $signed({14'b0, r_q40}) - $signed({8'b0, newest_reg});
                    diff_reg <= (fcnt_reg >= CW'(2)) ?
                                $signed({1'b0, newest_reg}) - $signed({1'b0, f1_reg}) : '0;
                    div_dvd_reg   <= DIVD_W'(sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg));
                    div_dvs_reg   <= DIVS_W'({fr_eff, 1'b0});
                    state_reg     <= ST_IDIV;
                end
                ST_IDIV: begin
                    if (div_done) begin
                        integ_reg <= sum_reg[63] ? -$signed(div_quo) : $signed(div_quo);
                        state_reg <= ST_DER_LO;
                    end
                end
                ST_DER_LO: state_reg <= ST_DER_HI;
                ST_DER_HI: begin
                    plo_reg   <= product[63:0];
                    state_reg <= ST_DER_ACC;
                end
                ST_DER_ACC: begin
                    der_reg   <= diff_reg[FREQ_W] ? -$signed(dmag64) : $signed(dmag64);
                    term_reg  <= 2'd0;
                    asum_reg  <= '0;
                    state_reg <= ST_MG_LO;
                end
                ST_MG_LO: state_reg <= ST_MG_HI;
                ST_MG_HI: begin
                    plo_reg   <= product[63:0];
                    state_reg <= ST_MG_ACC;
                end
                ST_MG_ACC: begin
                    asum_reg <= tneg ? asum_reg - $signed({3'b0, msat})
                                     : asum_reg + $signed({3'b0, msat});
                    if (term_reg == 2'd2) begin
                        state_reg <= ST_XMUL;
                    end else begin
                        term_reg  <= term_reg + 1'b1;
                        state_reg <= ST_MG_LO;
                    end
                end
                ST_XMUL: begin
                    asum_reg  <= asat;
                    state_reg <= ST_XCALC;
                end
                ST_XCALC: begin
                    if (sv[66]) begin
                        target_reg <= '0;
                        state_reg  <= ST_FLT1;
                    end else if (sv >= $signed({35'b0, range_eff, 1'b0})) begin
                        target_reg <= '1;
                        state_reg  <= ST_FLT1;
                    end else begin
                        div_dvd_reg   <= DIVD_W'({sv[31:0], 11'b0});
                        div_dvs_reg   <= DIVS_W'(range_eff);
                        state_reg     <= ST_WDIV;
                    end
                end
                ST_WDIV: begin
                    if (div_done) begin
                        target_reg <= div_quo[WORD_W-1:0];
                        state_reg  <= ST_FLT1;
                    end
                end
                ST_FLT1: state_reg <= ST_FLT2;
                ST_FLT2: begin
                    plo_reg   <= product[63:0];
                    state_reg <= ST_FLT3;
                end
                ST_FLT3: begin
                    filt_reg  <= fsum[27:16];
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_kind_reg   <= kind_reg;
                        m_data_reg   <= {filt_reg, target_reg,
                                         (fcnt_reg != '0) ? newest_reg : {FREQ_W{1'b0}}};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_kind_reg;

endmodule

[rtl/pdo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pdo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

[rtl/pdo_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module pdo_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pdo_pkg::div_req_t       req,
    output logic                    done,
    output logic [pdo_pkg::QUO_W-1:0] quotient
);
    import pdo_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (req.start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/pdo_mul.sv]
// Shared unsigned multiplier with registered product.
module pdo_mul (
    input  logic                       aclk,
    input  pdo_pkg::mul_req_t          req,
    output logic [pdo_pkg::PROD_W-1:0] product
);
    import pdo_pkg::*;

    always_ff @(posedge aclk) begin
        product <= PROD_W'(req.a) * PROD_W'(req.b);
    end

endmodule

[rtl/pdo_checker.sv]
// Port-level assertions for the oscillator controller, bound to the top level.
module pdo_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import pdo_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_NOPAIR || m_tuser == KIND_PAIR ||
                      m_tuser == KIND_DAC))
        else $error("illegal result kind");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        (s_tuser == REQ_REF || s_tuser == REQ_OSC || s_tuser == REQ_TICK) |=> !s_tready)
        else $error("input still ready after an accepted transaction");

endmodule

bind pps_disciplined_oscillator_pid pdo_checker u_pdo_checker (
    .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser
);
